// ----- sv/assert_macros.svh -----
// Assertion macros for the checker file of the depression storage block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define DSS_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("dss check failed");

// Next-cycle implication, off while reset is high.
`define DSS_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("dss check failed");

`endif

// ----- sv/dss_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, register indexes, exp(-x) table and saturation helper
// for the depression storage step core. No dependencies.
package dss_pkg;

  // Field widths
  localparam int CELL_W     = 12;
  localparam int CAP_W      = 31;
  localparam int DATA_W     = 32;
  localparam int FRAC_W     = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  localparam int CELLS_DEFAULT = 4096;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INIT_FRAC  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMPOUND_EN = 1'd1;

  // 0.001 mm and 1.0 in Q16.16
  localparam logic [CAP_W-1:0]  TINY_Q16 = 31'd66;
  localparam logic [FRAC_W-1:0] ONE_Q16  = 17'h10000;

  // exp(-x) table: Q1.30 entries, x in Q16.16 spanning 2^EXP_SPAN_W.
  // Table size is a power of two so index and fraction are bit fields of x.
  localparam int EXP_TABLE_SIZE = 256;
  localparam int EXP_SPAN_W     = 20;
  localparam int EXP_STEP       = (1 << EXP_SPAN_W) / EXP_TABLE_SIZE;
  localparam int EXP_STEP_W     = $clog2(EXP_STEP);
  localparam int EXP_IDX_W      = $clog2(EXP_TABLE_SIZE);
  localparam int EXP_W          = 31;

  typedef logic [EXP_W-1:0] exp_tab_t [EXP_TABLE_SIZE];

  // Floor of num / den for non-negative operands below 2^62, by shift and subtract
  function automatic longint div_floor(input longint num, input longint den);
    longint q;
    longint r;
    q = 0;
    r = 0;
    for (int i = 62; i >= 0; i--) begin
      r = (r <<< 1) | ((num >>> i) & longint'(1));
      if (r >= den) begin
        r = r - den;
        q = q | (longint'(1) <<< i);
      end
    end
    return q;
  endfunction

  // Build the table at elaboration: Taylor sum of exp(h), rounded inverse,
  // then repeated rounded products.
  function automatic exp_tab_t exp_build();
    longint h;
    longint term;
    longint total;
    longint eneg;
    exp_tab_t tab;
    h     = longint'(EXP_STEP) <<< 14;
    term  = longint'(1) <<< 30;
    total = longint'(1) <<< 30;
    for (int n = 1; n <= 40; n++) begin
      term  = div_floor(term * h, longint'(n) * (longint'(1) <<< 30));
      total = total + term;
    end
    eneg   = div_floor((longint'(1) <<< 60) + (total >>> 1), total);
    tab[0] = EXP_W'(longint'(1) <<< 30);
    for (int n = 1; n < EXP_TABLE_SIZE; n++) begin
      tab[n] = EXP_W'((longint'(tab[n-1]) * eneg + (longint'(1) <<< 29)) >>> 30);
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = exp_build();

  // Clamp a 34-bit signed sum to the 32-bit signed range
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [33:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > 34'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -34'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- sv/dss_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/depression_storage_step_core.sv -----
`timescale 1ns / 1ps
// Depression storage step core: per-cell Linsley depression storage update.
// Depends on dss_pkg and dss_ram.
//
// One grid cell per beat, one beat per clock when cells differ and the output
// is not stalled: an item passes 32 pipeline stages and the output register. The
// depth of each cell lives in a RAM that is read when an item leaves stage 1
// and written when it leaves the last stage; an item whose cell is still in
// flight waits in stage 1 until that write is done, so a run of beats on one
// cell does not overlap in the pipeline. The two divisions (deficit ratio and
// pe/capacity) are restoring dividers with one quotient bit per stage, 20
// stages for pe/capacity. After reset the core zeroes the RAM, one cell a
// cycle; in_ready stays low during that pass, and configuration writes are
// taken as usual.
module depression_storage_step_core #(
  parameter int CELLS = dss_pkg::CELLS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [dss_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dss_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [dss_pkg::CELL_W-1:0]          cell_req,
  input  logic                                start_req,
  input  logic [dss_pkg::CAP_W-1:0]           capacity,
  input  logic signed [dss_pkg::DATA_W-1:0]   excess_precip,
  input  logic signed [dss_pkg::DATA_W-1:0]   potential_et,
  input  logic signed [dss_pkg::DATA_W-1:0]   intercept_evap,
  input  logic signed [dss_pkg::DATA_W-1:0]   hand_evap,
  input  logic                                impounded,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [dss_pkg::DATA_W-1:0]   storage,
  output logic signed [dss_pkg::DATA_W-1:0]   evaporation,
  output logic signed [dss_pkg::DATA_W-1:0]   runoff,
  output logic signed [dss_pkg::DATA_W-1:0]   impound_volume
);

  import dss_pkg::*;

  localparam int AW        = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int QX_W      = EXP_SPAN_W;
  localparam int QR_W      = FRAC_W;
  localparam int CELL_HALF = CELL_W / 2;

  // Stage map
  localparam int S_IN   = 0;
  localparam int S_RD   = 1;
  localparam int S_MEM  = 2;
  localparam int S_PRE  = 3;
  localparam int S_DIV  = 4;
  localparam int S_TAB  = S_DIV + QX_W;
  localparam int S_INT  = S_TAB + 1;
  localparam int S_EXP  = S_INT + 1;
  localparam int S_T    = S_EXP + 1;
  localparam int S_DEL  = S_T + 1;
  localparam int S_ADD  = S_DEL + 1;
  localparam int S_EVAP = S_ADD + 1;
  localparam int S_IMP  = S_EVAP + 1;
  localparam int NS     = S_IMP + 1;

  typedef struct packed {
    logic [CELL_W-1:0]        cellw;
    logic [AW-1:0]            addr;
    logic                     start;
    logic                     imp;
    logic [CAP_W-1:0]         cap;
    logic signed [DATA_W-1:0] pe;
    logic signed [DATA_W-1:0] pet;
    logic signed [DATA_W-1:0] ei;
    logic signed [DATA_W-1:0] he;
    logic [CAP_W-1:0]         prod;
    logic signed [DATA_W-1:0] sd;
    logic signed [33:0]       deficit;
    logic signed [DATA_W-1:0] dem;
    logic                     tiny;
    logic                     full;
    logic                     pos;
    logic                     xover;
    logic [CAP_W-1:0]         rem_x;
    logic [QX_W-1:0]          bits_x;
    logic [QX_W-1:0]          q_x;
    logic [CAP_W-1:0]         rem_r;
    logic [QR_W-1:0]          bits_r;
    logic [QR_W-1:0]          q_r;
    logic [EXP_W-1:0]         a;
    logic [EXP_W-1:0]         d;
    logic [EXP_STEP_W-1:0]    f;
    logic [EXP_W+EXP_STEP_W-1:0] dfp;
    logic [EXP_W-1:0]         e;
    logic [CAP_W-1:0]         t;
    logic [DATA_W-1:0]        delta;
    logic signed [DATA_W-1:0] sd1;
    logic signed [DATA_W-1:0] sr;
    logic signed [DATA_W-1:0] ed;
    logic signed [DATA_W-1:0] pv;
  } pipe_t;

  // Reduce a cell index modulo CELLS over shifted subtracts hi..lo
  function automatic logic [CELL_W-1:0] cell_reduce(input logic [CELL_W-1:0] c,
                                                   input int hi, input int lo);
    logic [CELL_W-1:0] v;
    logic [32:0]       m;
    v = c;
    for (int k = hi; k >= lo; k--) begin
      m = 33'(CELLS) << k;
      if (33'(v) >= m) begin
        v = v - m[CELL_W-1:0];
      end
    end
    return v;
  endfunction

  logic [FRAC_W-1:0] init_frac;
  logic              imp_en;
  logic              clearing;
  logic [AW-1:0]     clr_cnt;

  pipe_t st [NS];
  pipe_t nx [NS];
  logic  v  [NS];

  logic in_fire;
  logic en_b;
  logic hz;
  logic mv0;
  logic mv1;
  logic ld0;
  logic ld1;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] ram_q;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      init_frac <= '0;
      imp_en    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INIT_FRAC:  init_frac <= cfg_data[FRAC_W-1:0];
        REG_IMPOUND_EN: imp_en    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Zero the depth RAM after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      if (clr_cnt == AW'(CELLS - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  // Hold stage 1 while its cell is still in flight further down
  always_comb begin
    hz = 1'b0;
    for (int i = S_MEM; i < NS; i++) begin
      if (v[i] && (st[i].addr == st[S_RD].addr)) begin
        hz = 1'b1;
      end
    end
  end

  // Back segment advances whenever the output register can take a beat
  assign en_b     = !out_valid || out_ready;
  assign mv1      = v[S_RD] && en_b && !hz;
  assign ld1      = !v[S_RD] || mv1;
  assign mv0      = v[S_IN] && ld1;
  assign ld0      = !v[S_IN] || mv0;
  assign in_ready = ld0 && !clearing;
  assign in_fire  = in_valid && in_ready;

  // Stage 0: capture the beat, first half of the cell reduction
  always_comb begin
    nx[S_IN]       = '0;
    nx[S_IN].cellw = cell_reduce(cell_req, CELL_W - 1, CELL_HALF);
    nx[S_IN].start = start_req;
    nx[S_IN].imp   = impounded;
    nx[S_IN].cap   = capacity;
    nx[S_IN].pe    = excess_precip;
    nx[S_IN].pet   = potential_et;
    nx[S_IN].ei    = intercept_evap;
    nx[S_IN].he    = hand_evap;
  end

  // Stage 1: finish the reduction into a RAM address
  always_comb begin
    logic [CELL_W-1:0] c;
    c             = cell_reduce(st[S_IN].cellw, CELL_HALF - 1, 0);
    nx[S_RD]      = st[S_IN];
    nx[S_RD].addr = AW'(c);
  end

  // Stage 2: start depth = fraction * capacity while the RAM reads
  always_comb begin
    logic [FRAC_W-1:0]       fr;
    logic [FRAC_W+CAP_W-1:0] m;
    fr             = (init_frac > ONE_Q16) ? ONE_Q16 : init_frac;
    m              = (FRAC_W + CAP_W)'(fr) * (FRAC_W + CAP_W)'(st[S_RD].cap);
    nx[S_MEM]      = st[S_RD];
    nx[S_MEM].prod = m[CAP_W+15:16];
  end

  // Stage 3: pick the depth, classify, demand, seed the dividers
  always_comb begin
    pipe_t             p;
    logic signed [33:0] dsum;
    p         = st[S_MEM];
    p.sd      = p.start ? $signed({1'b0, p.prod}) : $signed(ram_q);
    p.deficit = $signed({3'b000, p.cap}) - $signed({{2{p.sd[DATA_W-1]}}, p.sd});
    p.tiny    = (p.cap < TINY_Q16);
    p.full    = (p.deficit < 34'sd66);
    p.pos     = (p.pe > 32'sd0);
    p.xover   = ($signed({{4{p.pe[DATA_W-1]}}, p.pe}) >= $signed({1'b0, p.cap, 4'b0000}));
    dsum      = $signed({{2{p.pet[DATA_W-1]}}, p.pet}) - $signed({{2{p.ei[DATA_W-1]}}, p.ei})
              - $signed({{2{p.he[DATA_W-1]}}, p.he});
    p.dem     = sat32(dsum);
    p.rem_x   = CAP_W'(p.pe[DATA_W-2:4]);
    p.bits_x  = {p.pe[3:0], 16'h0000};
    p.q_x     = '0;
    p.rem_r   = p.deficit[DATA_W-1:1];
    p.bits_r  = {p.deficit[0], 16'h0000};
    p.q_r     = '0;
    nx[S_PRE] = p;
  end

  // Restoring dividers, one quotient bit per stage
  for (genvar k = 0; k < QX_W; k++) begin : g_div
    always_comb begin
      pipe_t       p;
      logic [31:0] tx;
      logic [31:0] tr;
      p  = st[S_DIV+k-1];
      tx = {p.rem_x, p.bits_x[QX_W-1]};
      if (tx >= {1'b0, p.cap}) begin
        p.rem_x = CAP_W'(tx - {1'b0, p.cap});
        p.q_x   = {p.q_x[QX_W-2:0], 1'b1};
      end else begin
        p.rem_x = tx[CAP_W-1:0];
        p.q_x   = {p.q_x[QX_W-2:0], 1'b0};
      end
      p.bits_x = p.bits_x << 1;
      tr = {p.rem_r, p.bits_r[QR_W-1]};
      if (k < QR_W) begin
        if (tr >= {1'b0, p.cap}) begin
          p.rem_r = CAP_W'(tr - {1'b0, p.cap});
          p.q_r   = {p.q_r[QR_W-2:0], 1'b1};
        end else begin
          p.rem_r = tr[CAP_W-1:0];
          p.q_r   = {p.q_r[QR_W-2:0], 1'b0};
        end
        p.bits_r = p.bits_r << 1;
      end
      nx[S_DIV+k] = p;
    end
  end

  // Table lookup: neighbors of x, the last entry leans toward zero
  always_comb begin
    pipe_t                p;
    logic [EXP_IDX_W-1:0] idx;
    logic [EXP_W-1:0]     b;
    p   = st[S_TAB-1];
    idx = p.q_x[QX_W-1 -: EXP_IDX_W];
    b   = (idx == EXP_IDX_W'(EXP_TABLE_SIZE - 1)) ? '0 : EXP_TAB[idx + 1'b1];
    p.a = EXP_TAB[idx];
    p.d = p.a - b;
    p.f = p.q_x[EXP_STEP_W-1:0];
    nx[S_TAB] = p;
  end

  // Interpolation product
  always_comb begin
    nx[S_INT]     = st[S_TAB];
    nx[S_INT].dfp = (EXP_W + EXP_STEP_W)'(st[S_TAB].d) * (EXP_W + EXP_STEP_W)'(st[S_TAB].f);
  end

  // E = a - slope; zero past the end of the table
  always_comb begin
    nx[S_EXP]   = st[S_INT];
    nx[S_EXP].e = st[S_INT].xover ? '0 :
                  (st[S_INT].a - st[S_INT].dfp[EXP_W+EXP_STEP_W-1:EXP_STEP_W]);
  end

  // t = pe * E in Q16.16
  always_comb begin
    logic [CAP_W+EXP_W-1:0] m;
    m           = (CAP_W + EXP_W)'(st[S_EXP].pe[CAP_W-1:0]) * (CAP_W + EXP_W)'(st[S_EXP].e);
    nx[S_T]     = st[S_EXP];
    nx[S_T].t   = m[CAP_W+29:30];
  end

  // delta = t * r
  always_comb begin
    logic [CAP_W+QR_W-1:0] m;
    m               = (CAP_W + QR_W)'(st[S_T].t) * (CAP_W + QR_W)'(st[S_T].q_r);
    nx[S_DEL]       = st[S_T];
    nx[S_DEL].delta = m[CAP_W+QR_W-1:16];
  end

  // Split precipitation into stored part and runoff
  always_comb begin
    pipe_t             p;
    logic [DATA_W-1:0] dl;
    p  = st[S_DEL];
    dl = ($signed({2'b00, p.delta}) > p.deficit) ? p.deficit[DATA_W-1:0] : p.delta;
    if (p.tiny) begin
      p.sd1 = '0;
      p.sr  = p.pe;
    end else if (p.full) begin
      p.sd1 = $signed({1'b0, p.cap});
      p.sr  = p.pe;
    end else if (p.pos) begin
      p.sd1 = p.sd + $signed(dl);
      p.sr  = p.pe - $signed(dl);
    end else begin
      p.sd1 = p.sd + p.pe;
      p.sr  = '0;
    end
    nx[S_ADD] = p;
  end

  // Evaporation, limited by the store, negative demand refills it
  always_comb begin
    pipe_t                    p;
    logic signed [DATA_W-1:0] posd;
    p    = st[S_ADD];
    posd = p.dem[DATA_W-1] ? '0 : p.dem;
    if (p.sd1 > 32'sd0) begin
      p.ed = (posd < p.sd1) ? p.dem : p.sd1;
      p.sd = sat32(34'(p.sd1) - 34'(p.ed));
    end else begin
      p.ed = '0;
      p.sd = '0;
    end
    nx[S_EVAP] = p;
  end

  // Impoundment moves runoff and storage to the pothole
  always_comb begin
    pipe_t p;
    p = st[S_EVAP];
    if (imp_en && p.imp) begin
      p.pv = sat32(34'(p.sr) + 34'(p.sd));
      p.sr = '0;
      p.sd = '0;
    end else begin
      p.pv = '0;
    end
    nx[S_IMP] = p;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NS; i++) begin
        v[i] <= 1'b0;
      end
    end else begin
      if (ld0) begin
        v[S_IN] <= in_fire;
      end
      if (ld1) begin
        v[S_RD] <= mv0;
      end
      if (en_b) begin
        v[S_MEM] <= mv1;
        for (int i = S_PRE; i < NS; i++) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      st[S_IN] <= nx[S_IN];
    end
    if (mv0) begin
      st[S_RD] <= nx[S_RD];
    end
    if (mv1) begin
      st[S_MEM] <= nx[S_MEM];
    end
    if (en_b) begin
      for (int i = S_PRE; i < NS; i++) begin
        st[i] <= nx[i];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_b) begin
      out_valid <= v[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en_b && v[NS-1]) begin
      storage        <= st[NS-1].sd;
      evaporation    <= st[NS-1].ed;
      runoff         <= st[NS-1].sr;
      impound_volume <= st[NS-1].pv;
    end
  end

  // Write back the new depth as the beat leaves, or zero during the sweep
  assign ram_we    = clearing || (en_b && v[NS-1]);
  assign ram_waddr = clearing ? clr_cnt : st[NS-1].addr;
  assign ram_wdata = clearing ? '0 : st[NS-1].sd;

  dss_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CELLS)
  ) u_depth (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (mv1),
    .raddr(st[S_RD].addr),
    .rdata(ram_q)
  );

endmodule

// ----- sv/dss_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the depression storage step core, bound to the top.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module dss_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] storage,
  input logic [31:0] runoff,
  input logic [31:0] impound_volume
);

  // A stalled result holds
  `DSS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(storage))

  // Stored depth never goes negative
  `DSS_ASSERT_IMPL(a_depth_nonneg, out_valid, !storage[31])

  // Impounded beats leave nothing in the store or as runoff
  `DSS_ASSERT_IMPL(a_impound_empty, out_valid && (impound_volume != 32'd0),
                   (storage == 32'd0) && (runoff == 32'd0))

  // The RAM sweep after reset blocks input
  `DSS_ASSERT_IMPL(a_sweep_blocks, $past(rst), !in_ready)

endmodule

bind depression_storage_step_core dss_checker u_dss_checker (.*);
